@@ design/raster_circle_clear_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RASTER_CIRCLE_CLEAR_DEFINES_SVH
`define RASTER_CIRCLE_CLEAR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raster_circle_clear: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raster_circle_clear: check failed");

`endif

@@ design/rcc_pkg.sv @@
package rcc_pkg;

  // Map and field sizes
  localparam int MAX_WIDTH        = 256;
  localparam int MAX_HEIGHT       = 256;
  localparam int PIXEL_BITS       = 8;
  localparam int RADIUS_FRAC_BITS = 4;

  localparam int KIND_W     = 2;
  localparam int COORD_W    = 8;
  localparam int EXT_W      = 9;
  localparam int RADIUS_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Disc arithmetic widths
  localparam int RAD_ROUND = (1 << RADIUS_FRAC_BITS) - 1;
  localparam int CEIL_W    = RADIUS_W - RADIUS_FRAC_BITS + 1;
  localparam int SPAN_W    = CEIL_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int R2_W      = 2 * RADIUS_W;
  localparam int DIST_W    = SQ_W + 1 + 2 * RADIUS_FRAC_BITS;
  localparam int CMP_W     = (DIST_W > R2_W) ? DIST_W : R2_W;

  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [EXT_W-1:0]      ext_t;
  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [RADIUS_W-1:0]   radius_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  // Item kinds
  localparam kind_t KIND_WRITE = KIND_W'(0);
  localparam kind_t KIND_READ  = KIND_W'(1);
  localparam kind_t KIND_CLEAR = KIND_W'(2);
  localparam kind_t KIND_NONE  = KIND_W'(3);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY  = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_ACCESS,
    ST_BOX,
    ST_CHECK,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic pix_calc;
    logic pix_access;
    logic box_calc;
    logic row_start;
    logic cell_step;
    logic out_load;
  } rcc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  box_empty;
    logic  row_last;
    logic  col_last;
  } rcc_sts_t;

endpackage

@@ design/rcc_in_if.sv @@
interface rcc_in_if import rcc_pkg::*;;
  logic    valid;
  logic    ready;
  kind_t   kind;
  coord_t  x_pos;
  coord_t  y_pos;
  pix_t    pixel_in;
  radius_t radius;

  modport source (output valid, kind, x_pos, y_pos, pixel_in, radius, input ready);
  modport sink (input valid, kind, x_pos, y_pos, pixel_in, radius, output ready);
endinterface

@@ design/rcc_out_if.sv @@
interface rcc_out_if import rcc_pkg::*;;
  logic valid;
  logic ready;
  pix_t pixel_value;
  logic in_range;

  modport source (output valid, pixel_value, in_range, input ready);
  modport sink (input valid, pixel_value, in_range, output ready);
endinterface

@@ design/rcc_ctrl.sv @@
module rcc_ctrl import rcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  rcc_sts_t sts_i,
  output rcc_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a word when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        state_d = (sts_i.kind == KIND_CLEAR) ? ST_BOX : ST_ACCESS;
      end
      ST_ACCESS: state_d = ST_DONE;
      ST_BOX:    state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = sts_i.box_empty ? ST_DONE : ST_ROW;
      end
      ST_ROW:    state_d = ST_CELL;
      ST_CELL: begin
        if (sts_i.col_last) state_d = sts_i.row_last ? ST_DONE : ST_ROW;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.load       = in_valid_i;
      ST_ADDR:   cmd_o.pix_calc   = 1'b1;
      ST_ACCESS: cmd_o.pix_access = 1'b1;
      ST_BOX:    cmd_o.box_calc   = 1'b1;
      ST_CHECK:  ;
      ST_ROW:    cmd_o.row_start  = 1'b1;
      ST_CELL:   cmd_o.cell_step  = 1'b1;
      ST_DONE:   cmd_o.out_load   = out_free;
      default:   ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/rcc_dp.sv @@
module rcc_dp import rcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  kind_t                 kind_i,
  input  coord_t                x_pos_i,
  input  coord_t                y_pos_i,
  input  pix_t                  pixel_in_i,
  input  radius_t               radius_i,
  input  rcc_cmd_t              cmd_i,
  output rcc_sts_t              sts_o,
  output pix_t                  pixel_value_o,
  output logic                  in_range_o
);

  // Configuration registers
  ext_t width_q, height_q;
  pix_t empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= EXT_W'(MAX_WIDTH);
      height_q <= EXT_W'(MAX_HEIGHT);
      empty_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i[EXT_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[EXT_W-1:0];
        CFG_EMPTY:  empty_q  <= cfg_data_i[PIXEL_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Extents clamped to 1..max
  ext_t w_use, h_use;

  always_comb begin
    w_use = width_q;
    if (width_q == '0) w_use = EXT_W'(1);
    else if (width_q > EXT_W'(MAX_WIDTH)) w_use = EXT_W'(MAX_WIDTH);
    h_use = height_q;
    if (height_q == '0) h_use = EXT_W'(1);
    else if (height_q > EXT_W'(MAX_HEIGHT)) h_use = EXT_W'(MAX_HEIGHT);
  end

  // Captured item
  kind_t   kind_q;
  coord_t  x_q, y_q;
  pix_t    pin_q;
  radius_t rad_q;
  logic    inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      x_q      <= x_pos_i;
      y_q      <= y_pos_i;
      pin_q    <= pixel_in_i;
      rad_q    <= radius_i;
      inside_q <= (kind_i != KIND_NONE) && (EXT_W'(x_pos_i) < w_use) &&
                  (EXT_W'(y_pos_i) < h_use);
    end
  end

  // Single pixel address: x * height + y
  logic [COORD_W+EXT_W-1:0] pix_prod;
  addr_t                    addr_q;

  assign pix_prod = x_q * h_use;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_calc) addr_q <= pix_prod[ADDR_W-1:0] + ADDR_W'(y_q);
  end

  // Bounding box of the disc, clipped to the map
  logic [RADIUS_W:0]   rad_up;
  logic [CEIL_W-1:0]   half_side;
  logic [SPAN_W-1:0]   x_w, y_w, c_w, x_end, y_end;
  coord_t              sx_d, sy_d;
  ext_t                ex_d, ey_d;
  coord_t              sx_q, sy_q;
  ext_t                ex_q, ey_q;
  logic [R2_W-1:0]     r2_d, r2_q;

  assign rad_up    = {1'b0, rad_q} + (RADIUS_W+1)'(RAD_ROUND);
  assign half_side = CEIL_W'(rad_up >> RADIUS_FRAC_BITS);
  assign x_w       = SPAN_W'(x_q);
  assign y_w       = SPAN_W'(y_q);
  assign c_w       = SPAN_W'(half_side);
  assign x_end     = x_w + c_w;
  assign y_end     = y_w + c_w;
  assign sx_d      = (x_w >= c_w) ? COORD_W'(x_w - c_w) : '0;
  assign sy_d      = (y_w >= c_w) ? COORD_W'(y_w - c_w) : '0;
  assign ex_d      = (x_end > SPAN_W'(w_use)) ? w_use : EXT_W'(x_end);
  assign ey_d      = (y_end > SPAN_W'(h_use)) ? h_use : EXT_W'(y_end);
  assign r2_d      = rad_q * rad_q;

  // Row and column walkers
  coord_t             i_q, j_q;
  logic [SQ_W-1:0]    dx2_q;
  addr_t              base_q;
  coord_t             adx, ady;
  logic [SQ_W-1:0]    dx_sq, dy_sq;
  logic [COORD_W+EXT_W-1:0] row_prod;

  assign adx      = (i_q >= x_q) ? (i_q - x_q) : (x_q - i_q);
  assign ady      = (j_q >= y_q) ? (j_q - y_q) : (y_q - j_q);
  assign dx_sq    = adx * adx;
  assign dy_sq    = ady * ady;
  assign row_prod = i_q * h_use;

  assign sts_o.kind      = kind_q;
  assign sts_o.box_empty = (EXT_W'(sx_q) >= ex_q) || (EXT_W'(sy_q) >= ey_q);
  assign sts_o.row_last  = (EXT_W'(i_q) + EXT_W'(1)) == ex_q;
  assign sts_o.col_last  = (EXT_W'(j_q) + EXT_W'(1)) == ey_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.box_calc) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      ex_q <= ex_d;
      ey_q <= ey_d;
      r2_q <= r2_d;
      i_q  <= sx_d;
    end
    if (cmd_i.row_start) begin
      dx2_q  <= dx_sq;
      base_q <= row_prod[ADDR_W-1:0];
      j_q    <= sy_q;
    end
    if (cmd_i.cell_step) begin
      j_q <= j_q + COORD_W'(1);
      if (sts_o.col_last) i_q <= i_q + COORD_W'(1);
    end
  end

  // Cell pipeline: square, then sum and compare
  logic               s1_valid_q;
  logic [SQ_W-1:0]    s1_dx2_q, s1_dy2_q;
  addr_t              s1_addr_q;
  logic [SQ_W:0]      sq_sum;
  logic [CMP_W-1:0]   dist_scaled;
  logic               hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= cmd_i.cell_step;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_step) begin
      s1_dx2_q  <= dx2_q;
      s1_dy2_q  <= dy_sq;
      s1_addr_q <= base_q + ADDR_W'(j_q);
    end
  end

  assign sq_sum      = {1'b0, s1_dx2_q} + {1'b0, s1_dy2_q};
  assign dist_scaled = CMP_W'(sq_sum) << (2 * RADIUS_FRAC_BITS);
  assign hit         = s1_valid_q && (dist_scaled < CMP_W'(r2_q));

  // Pixel store write port
  logic  mem_we;
  addr_t mem_waddr;
  pix_t  mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr_q;
    mem_wdata = empty_q;
    if (cmd_i.pix_access && (kind_q == KIND_WRITE) && inside_q) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = pin_q;
    end else if (hit) begin
      mem_we = 1'b1;
    end
  end

  // Pixel store, registered read
  pix_t pixel_store_q [MEM_DEPTH];
  pix_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) pixel_store_q[mem_waddr] <= mem_wdata;
    rdata_q <= pixel_store_q[addr_q];
  end

  // Result word
  pix_t pixel_value_q;
  logic in_range_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_value_q <= ((kind_q == KIND_READ) && inside_q) ? rdata_q : '0;
      in_range_q    <= inside_q;
    end
  end

  assign pixel_value_o = pixel_value_q;
  assign in_range_o    = in_range_q;

endmodule

@@ design/raster_circle_clear.sv @@
// Pixel map of up to 256 x 256 cells held in one single-port-write memory, with
// write, read and disc-clear items. A write or read goes through capture, address
// multiply, memory access and result load. A clear goes through capture, address,
// bounds and radius square and box test, then walks the clipped bounding box row by
// row over the memory write port (a row start step for each row and a cell step for
// each cell), then result load. One item is worked on at a time; the next item is
// accepted as soon as the result word sits in the output register, even if it is
// not taken yet. The memory is not cleared after reset: read only cells that were
// written.
module raster_circle_clear import rcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rcc_in_if.sink                in_i,
  rcc_out_if.source             out_o
);

  rcc_cmd_t cmd;
  rcc_sts_t sts;

  // Sequencer
  rcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Map store and arithmetic
  rcc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (in_i.kind),
    .x_pos_i       (in_i.x_pos),
    .y_pos_i       (in_i.y_pos),
    .pixel_in_i    (in_i.pixel_in),
    .radius_i      (in_i.radius),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pixel_value_o (out_o.pixel_value),
    .in_range_o    (out_o.in_range)
  );

endmodule

@@ design/rcc_checker.sv @@
`include "raster_circle_clear_defines.svh"

module rcc_checker import rcc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input pix_t pixel_value_i,
  input logic in_range_i
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled word stays put
  `RCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  `RCC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(pixel_value_i))

  // One item at a time: no acceptance right after an acceptance
  `RCC_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_acc, !in_ready_i)

  // Out-of-map and unused items never return pixel data
  `RCC_ASSERT_NOW(a_zero_out, clk_i, rst_ni, out_valid_i && !in_range_i, pixel_value_i == '0)

endmodule

bind raster_circle_clear rcc_checker u_rcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .pixel_value_i (out_o.pixel_value),
  .in_range_i    (out_o.in_range)
);

@@ verif/tb.sv @@
module tb import rcc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 100;
  localparam int NUM_PHASES     = 7;

  // One command word and one result word
  typedef struct packed {
    kind_t   kind;
    coord_t  x;
    coord_t  y;
    pix_t    pixel;
    radius_t radius;
  } map_cmd_t;

  typedef struct packed {
    pix_t pixel;
    logic in_range;
  } map_result_t;

  // Mirror of the pixel map and its registers, plus the queue of expected results
  class map_scoreboard;
    pix_t        cells[MEM_DEPTH];
    ext_t        width_reg;
    ext_t        height_reg;
    pix_t        empty_reg;
    map_result_t expected_q[$];
    int          mismatches, checked;
    int          n_write, n_read, n_clear, n_none, n_off_map;

    function new();
      width_reg  = ext_t'(MAX_WIDTH);
      height_reg = ext_t'(MAX_HEIGHT);
      empty_reg  = '0;
      mismatches = 0;
      checked    = 0;
      n_write    = 0;
      n_read     = 0;
      n_clear    = 0;
      n_none     = 0;
      n_off_map  = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    // zero acts as one, large values saturate
    function int span(ext_t v, int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
    endfunction

    function int map_w();
      return span(width_reg, MAX_WIDTH);
    endfunction

    function int map_h();
      return span(height_reg, MAX_HEIGHT);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WIDTH:  width_reg = data;
        CFG_HEIGHT: height_reg = data;
        CFG_EMPTY:  empty_reg = data[PIXEL_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted command to the mirror and queue its result
    function void note_item(map_cmd_t c);
      int          w, h, cx, cy, reach, x0, x1, y0, y1, dx, dy;
      longint      r2, d2;
      map_result_t res;
      w = map_w();
      h = map_h();
      cx = int'(c.x);
      cy = int'(c.y);
      res.pixel = '0;
      res.in_range = (cx < w) && (cy < h);
      case (c.kind)
        KIND_WRITE: begin
          n_write++;
          if (res.in_range) cells[cx * h + cy] = c.pixel;
        end
        KIND_READ: begin
          n_read++;
          if (res.in_range) res.pixel = cells[cx * h + cy];
        end
        KIND_CLEAR: begin
          n_clear++;
          // box of half-side ceil(radius), clipped to the map
          reach = (int'(c.radius) + RAD_ROUND) >> RADIUS_FRAC_BITS;
          x0 = (cx - reach < 0) ? 0 : cx - reach;
          x1 = (cx + reach > w) ? w : cx + reach;
          y0 = (cy - reach < 0) ? 0 : cy - reach;
          y1 = (cy + reach > h) ? h : cy + reach;
          r2 = longint'(c.radius) * longint'(c.radius);
          for (int i = x0; i < x1; i++) begin
            for (int j = y0; j < y1; j++) begin
              dx = (i - cx) << RADIUS_FRAC_BITS;
              dy = (j - cy) << RADIUS_FRAC_BITS;
              d2 = longint'(dx) * dx + longint'(dy) * dy;
              if (d2 < r2) cells[i * h + j] = empty_reg;
            end
          end
        end
        default: begin
          n_none++;
          res.in_range = 1'b0;
        end
      endcase
      if (!res.in_range) n_off_map++;
      expected_q.push_back(res);
    endfunction

    function void check_result(pix_t pv, logic ir);
      map_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: pixel_value %h in_range %b",
                 $time, pv, ir);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (pv !== want.pixel) begin
        mismatches++;
        $display("%0t: pixel_value expected %h actual %h", $time, want.pixel, pv);
      end
      if (ir !== want.in_range) begin
        mismatches++;
        $display("%0t: in_range expected %b actual %b", $time, want.in_range, ir);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcc_in_if  cmd_if ();
  rcc_out_if res_if ();

  raster_circle_clear dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  map_scoreboard sb = new();

  int         tx_idle_pct = 6;
  int         rx_idle_pct = 56;
  logic       hold_rx;
  bit         hold_go = 1'b0;
  int         big_clears = 0;
  int         idle_cycles = 0;
  logic [15:0] recent_xy[$];

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  // Receiver: check every accepted result word, throttle ready at random
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) sb.check_result(res_if.pixel_value, res_if.in_range);
    res_if.ready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_rx <= 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(map_cmd_t c);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.kind     <= c.kind;
    cmd_if.x_pos    <= c.x;
    cmd_if.y_pos    <= c.y;
    cmd_if.pixel_in <= c.pixel;
    cmd_if.radius   <= c.radius;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_item(c);
  endtask

  task automatic put(kind_t k, int x, int y, int pix, int rad);
    map_cmd_t c;
    c.kind   = k;
    c.x      = coord_t'(x);
    c.y      = coord_t'(y);
    c.pixel  = pix_t'(pix);
    c.radius = radius_t'(rad);
    send_item(c);
  endtask

  // Drop valid and wait until every result word is back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_map(int w, int h, int ev);
    cfg_write(CFG_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_HEIGHT, CFG_DATA_W'(h));
    cfg_write(CFG_EMPTY, CFG_DATA_W'(ev));
    cfg_we <= 1'b0;
    @(posedge clk_i);
    recent_xy.delete();
  endtask

  // Random command, mostly inside the current map; reads favor recent writes
  function automatic map_cmd_t rand_item();
    map_cmd_t c;
    int       w, h, pick;
    logic [15:0] xy;
    w = sb.map_w();
    h = sb.map_h();
    c.pixel  = pix_t'($urandom_range(0, 255));
    c.radius = radius_t'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    if (pick < 40)      c.kind = KIND_WRITE;
    else if (pick < 75) c.kind = KIND_READ;
    else if (pick < 95) c.kind = KIND_CLEAR;
    else                c.kind = KIND_NONE;
    if ($urandom_range(0, 99) < 85) begin
      c.x = coord_t'($urandom_range(0, w - 1));
      c.y = coord_t'($urandom_range(0, h - 1));
    end else begin
      c.x = coord_t'($urandom_range(0, 255));
      c.y = coord_t'($urandom_range(0, 255));
    end
    if (c.kind == KIND_READ && recent_xy.size() != 0 && $urandom_range(0, 1) == 1) begin
      xy = recent_xy[$urandom_range(0, recent_xy.size() - 1)];
      c.x = xy[15:8];
      c.y = xy[7:0];
    end
    if (c.kind == KIND_WRITE) begin
      recent_xy.push_back({c.x, c.y});
      if (recent_xy.size() > 32) void'(recent_xy.pop_front());
    end
    // keep discs small on big maps, a couple of huge ones only
    if (c.kind == KIND_CLEAR && w * h > 4096) begin
      if (big_clears < 2 && $urandom_range(0, 199) == 0) begin
        c.radius = radius_t'($urandom_range(2048, 4095));
        big_clears++;
      end else begin
        c.radius = radius_t'($urandom_range(0, 160));
      end
    end
    return c;
  endfunction

  initial begin
    int ph_w[NUM_PHASES]  = '{256, 1, 13, 256, 511, 40, 256};
    int ph_h[NUM_PHASES]  = '{256, 1, 200, 2, 0, 40, 256};
    int ph_ev[NUM_PHASES] = '{8'h00, 8'hFF, 8'h3C, 8'h81, 8'h01, 8'hFE, 8'h7F};

    rst_ni          = 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_data        <= '0;
    cmd_if.valid    <= 1'b0;
    cmd_if.kind     <= KIND_WRITE;
    cmd_if.x_pos    <= '0;
    cmd_if.y_pos    <= '0;
    cmd_if.pixel_in <= '0;
    cmd_if.radius   <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full map: the first disc covers every cell so later reads never hit unwritten memory
    set_map(256, 256, 8'h5A);
    put(KIND_CLEAR, 128, 128, 0, 4095);
    // corners and pixel extremes
    put(KIND_WRITE, 0, 0, 8'hFF, 0);
    put(KIND_WRITE, 255, 255, 8'h00, 4095);
    put(KIND_WRITE, 255, 0, 8'h81, 0);
    put(KIND_WRITE, 0, 255, 8'h7E, 0);
    put(KIND_READ, 0, 0, 0, 0);
    put(KIND_READ, 255, 255, 8'hFF, 4095);
    put(KIND_READ, 255, 0, 0, 0);
    put(KIND_READ, 0, 255, 0, 0);
    // zero radius clears nothing
    put(KIND_CLEAR, 0, 0, 0, 0);
    put(KIND_READ, 0, 0, 0, 0);
    // radius of exactly one cell hits the centre only (strict compare)
    put(KIND_WRITE, 10, 11, 8'h33, 0);
    put(KIND_WRITE, 10, 10, 8'h44, 0);
    put(KIND_CLEAR, 10, 10, 0, 16);
    put(KIND_READ, 10, 10, 0, 0);
    put(KIND_READ, 10, 11, 0, 0);
    // fractional radius, and the unused kind
    put(KIND_CLEAR, 3, 3, 0, 17);
    put(KIND_NONE, 200, 100, 8'hAA, 12'h555);
    drain();

    // Degenerate extents: width 0 acts as 1, height above max saturates
    set_map(0, 511, 8'hC3);
    put(KIND_WRITE, 1, 0, 8'h11, 0);
    put(KIND_READ, 200, 5, 0, 0);
    put(KIND_READ, 0, 255, 0, 0);
    put(KIND_CLEAR, 5, 100, 0, 96);
    put(KIND_READ, 0, 100, 0, 0);
    put(KIND_READ, 0, 96, 0, 0);
    drain();

    // Random phases over several map settings and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        tx_idle_pct = 6;
        rx_idle_pct = 56;
      end else if (p < 4) begin
        tx_idle_pct = 56;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_map(ph_w[p], ph_h[p], ph_ev[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == 10) hold_go = 1'b1;
        send_item(rand_item());
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("run: %0d writes, %0d reads, %0d disc clears, %0d unused-kind words",
             sb.n_write, sb.n_read, sb.n_clear, sb.n_none);
    $display("     %0d off-map, %0d map settings, %0d results checked, %0d mismatches",
             sb.n_off_map, NUM_PHASES + 2, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
